// ===== design/dnc_pkg.sv =====
package dnc_pkg;

  // Day number offsets (MJD to JD, Gregorian cutover JD)
  localparam int JD_OFFSET  = 2400001;
  localparam int GREG_START = 2299161;

  // 4*Z - 7468865 written on the MJD: 4*MJD + 4*JD_OFFSET - 7468865
  localparam int N1_OFFSET = 4 * JD_OFFSET - 7468865;

  // B = A + 1524, Gregorian A carries an extra +1
  localparam int B_OFFSET_JUL  = 1524;
  localparam int B_OFFSET_GREG = 1525;

  // C numerator 20*B - 2442 is biased by C_BIAS*7305 to stay nonnegative
  localparam int C_DIV    = 7305;
  localparam int C_BIAS   = 5000;
  localparam int C_OFFSET = C_BIAS * C_DIV - 2442;

  localparam int D_MULT = 1461;

  // Year bases for the month split
  localparam int YEAR_BASE_LATE  = 4716;
  localparam int YEAR_BASE_EARLY = 4715;
  localparam int YEAR_MIN = 1;
  localparam int YEAR_MAX = 9999;

  // Exact floor division by reciprocal: M = ceil(2^S / D), S = N + ceil(log2 D)
  localparam int ALPHA_DIV   = 146097;
  localparam int ALPHA_SHIFT = 43;
  localparam longint unsigned ALPHA_MULT =
    ((64'd1 << ALPHA_SHIFT) + 64'(ALPHA_DIV) - 64'd1) / 64'(ALPHA_DIV);

  localparam int C_SHIFT = 41;
  localparam longint unsigned C_MULT =
    ((64'd1 << C_SHIFT) + 64'(C_DIV) - 64'd1) / 64'(C_DIV);

  // E = floor(10000*x / 306001); the 10000 is folded into the reciprocal
  localparam int E_DIV   = 306001;
  localparam int E_SCALE = 10000;
  localparam int E_SHIFT = 42;
  localparam longint unsigned E_MULT =
    64'(E_SCALE) * (((64'd1 << E_SHIFT) + 64'(E_DIV) - 64'd1) / 64'(E_DIV));

  localparam int Y100_DIV   = 100;
  localparam int Y100_SHIFT = 21;
  localparam longint unsigned Y100_MULT =
    ((64'd1 << Y100_SHIFT) + 64'(Y100_DIV) - 64'd1) / 64'(Y100_DIV);

  localparam int MONTH_WRAP = 14;
  localparam int MARCH      = 3;

  // Between the cycle front end and the date split
  typedef struct packed {
    logic [23:0] b;       // Meeus B, two's complement
    logic [27:0] n2;      // biased C numerator
    logic        julian;
  } mid_t;

  // Between the date split and the finish stages
  typedef struct packed {
    logic [15:0] year;    // two's complement, unchecked
    logic [3:0]  month;
    logic [4:0]  day;
    logic        julian;
  } date_t;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [8:0]  doy;
    logic        leap;
    logic        range_error;
  } res_t;

  // floor(30.6001 * e)
  function automatic logic [8:0] month_offset(input logic [3:0] e);
    logic [8:0] r;
    unique case (e)
      4'd0:  r = 9'd0;
      4'd1:  r = 9'd30;
      4'd2:  r = 9'd61;
      4'd3:  r = 9'd91;
      4'd4:  r = 9'd122;
      4'd5:  r = 9'd153;
      4'd6:  r = 9'd183;
      4'd7:  r = 9'd214;
      4'd8:  r = 9'd244;
      4'd9:  r = 9'd275;
      4'd10: r = 9'd306;
      4'd11: r = 9'd336;
      4'd12: r = 9'd367;
      4'd13: r = 9'd397;
      4'd14: r = 9'd428;
      4'd15: r = 9'd459;
    endcase
    return r;
  endfunction

  // floor(275 * m / 9) - 30
  function automatic logic [8:0] month_base(input logic [3:0] m);
    logic [8:0] r;
    unique case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd61;
      4'd4:    r = 9'd92;
      4'd5:    r = 9'd122;
      4'd6:    r = 9'd153;
      4'd7:    r = 9'd183;
      4'd8:    r = 9'd214;
      4'd9:    r = 9'd245;
      4'd10:   r = 9'd275;
      4'd11:   r = 9'd306;
      4'd12:   r = 9'd336;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== design/dnc_gregory.sv =====
module dnc_gregory (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [22:0]        mjd,
  output logic               out_valid,
  input  logic               out_ready,
  output dnc_pkg::mid_t      out_data
);

  logic [3:0]  vld;
  logic [3:0]  rdy;

  logic [23:0] z1;
  logic [24:0] n1;
  logic        jul1;
  logic [23:0] z2;
  logic [7:0]  alpha2;
  logic        jul2;
  logic [23:0] b3;
  logic        jul3;
  dnc_pkg::mid_t s4;

  logic [23:0] z_next;
  logic [25:0] n1_wide;
  logic        jul_next;
  logic [50:0] alpha_prod;
  logic [23:0] b_next;
  logic [28:0] b_wide;
  logic [28:0] n2_wide;

  // Per-stage ready: a stage takes new data when empty or draining
  always_comb begin
    rdy[3] = !vld[3] || out_ready;
    rdy[2] = !vld[2] || rdy[3];
    rdy[1] = !vld[1] || rdy[2];
    rdy[0] = !vld[0] || rdy[1];
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld[3];
  assign out_data  = s4;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= in_valid;
      if (rdy[1]) vld[1] <= vld[0];
      if (rdy[2]) vld[2] <= vld[1];
      if (rdy[3]) vld[3] <= vld[2];
    end
  end

  // Stage 1: JD, calendar select, alpha numerator
  assign z_next   = {mjd[22], mjd} + 24'(dnc_pkg::JD_OFFSET);
  assign jul_next = $signed(z_next) < $signed(24'(dnc_pkg::GREG_START));
  assign n1_wide  = {mjd[22], mjd, 2'b00} + 26'(dnc_pkg::N1_OFFSET);

  // Stage 2: alpha = floor(n1 / 146097)
  assign alpha_prod = 51'(n1) * 51'(dnc_pkg::ALPHA_MULT);

  // Stage 3: B
  assign b_next = jul2 ? z2 + 24'(dnc_pkg::B_OFFSET_JUL)
                       : z2 + 24'(dnc_pkg::B_OFFSET_GREG) + 24'(alpha2)
                         - 24'(alpha2[7:2]);

  // Stage 4: biased 20*B - 2442
  assign b_wide  = {{5{b3[23]}}, b3};
  assign n2_wide = (b_wide << 4) + (b_wide << 2) + 29'(dnc_pkg::C_OFFSET);

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      z1   <= z_next;
      n1   <= n1_wide[24:0];
      jul1 <= jul_next;
    end
    if (rdy[1]) begin
      z2     <= z1;
      alpha2 <= alpha_prod[dnc_pkg::ALPHA_SHIFT +: 8];
      jul2   <= jul1;
    end
    if (rdy[2]) begin
      b3   <= b_next;
      jul3 <= jul2;
    end
    if (rdy[3]) begin
      s4.b      <= b3;
      s4.n2     <= n2_wide[27:0];
      s4.julian <= jul3;
    end
  end

endmodule

// ===== design/dnc_split.sv =====
module dnc_split (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  dnc_pkg::mid_t      in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output dnc_pkg::date_t     out_data
);

  logic [3:0]  vld;
  logic [3:0]  rdy;

  logic [15:0] c5;
  logic [23:0] b5;
  logic        jul5;
  logic [15:0] c6;
  logic [8:0]  x6;
  logic        jul6;
  logic [15:0] c7;
  logic [8:0]  x7;
  logic [3:0]  e7;
  logic        jul7;
  dnc_pkg::date_t s8;

  logic [56:0] c_prod;
  logic [15:0] c_next;
  logic [25:0] c_wide;
  logic [25:0] c_scaled;
  logic [25:0] d_val;
  logic [25:0] x_wide;
  logic [46:0] e_prod;
  logic [8:0]  day_wide;
  logic [3:0]  month_next;
  logic [15:0] year_next;

  always_comb begin
    rdy[3] = !vld[3] || out_ready;
    rdy[2] = !vld[2] || rdy[3];
    rdy[1] = !vld[1] || rdy[2];
    rdy[0] = !vld[0] || rdy[1];
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld[3];
  assign out_data  = s8;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= in_valid;
      if (rdy[1]) vld[1] <= vld[0];
      if (rdy[2]) vld[2] <= vld[1];
      if (rdy[3]) vld[3] <= vld[2];
    end
  end

  // Stage 5: C = floor(n2 / 7305) - bias
  assign c_prod = 57'(in_data.n2) * 57'(dnc_pkg::C_MULT);
  assign c_next = c_prod[dnc_pkg::C_SHIFT +: 16] - 16'(dnc_pkg::C_BIAS);

  // Stage 6: D = floor(1461*C / 4), x = B - D
  assign c_wide   = {{10{c5[15]}}, c5};
  assign c_scaled = c_wide * 26'(dnc_pkg::D_MULT);
  assign d_val    = 26'($signed(c_scaled) >>> 2);
  assign x_wide   = {{2{b5[23]}}, b5} - d_val;

  // Stage 7: E = floor(10000*x / 306001)
  assign e_prod = 47'(x6) * 47'(dnc_pkg::E_MULT);

  // Stage 8: day, month, year
  assign day_wide   = x7 - dnc_pkg::month_offset(e7);
  assign month_next = (e7 < 4'(dnc_pkg::MONTH_WRAP)) ? e7 - 4'd1 : e7 - 4'd13;
  assign year_next  = (month_next > 4'd2) ? c7 - 16'(dnc_pkg::YEAR_BASE_LATE)
                                          : c7 - 16'(dnc_pkg::YEAR_BASE_EARLY);

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      c5   <= c_next;
      b5   <= in_data.b;
      jul5 <= in_data.julian;
    end
    if (rdy[1]) begin
      c6   <= c5;
      x6   <= x_wide[8:0];
      jul6 <= jul5;
    end
    if (rdy[2]) begin
      c7   <= c6;
      x7   <= x6;
      e7   <= e_prod[dnc_pkg::E_SHIFT +: 4];
      jul7 <= jul6;
    end
    if (rdy[3]) begin
      s8.year   <= year_next;
      s8.month  <= month_next;
      s8.day    <= day_wide[4:0];
      s8.julian <= jul7;
    end
  end

endmodule

// ===== design/dnc_finish.sv =====
module dnc_finish (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  dnc_pkg::date_t     in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output dnc_pkg::res_t      out_data
);

  logic [1:0]  vld;
  logic [1:0]  rdy;

  logic [13:0] y9;
  logic [7:0]  q9;
  logic [3:0]  m9;
  logic [4:0]  d9;
  logic        jul9;
  logic        err9;
  dnc_pkg::res_t res;

  logic        err_next;
  logic [28:0] y_prod;
  logic [14:0] hundreds;
  logic        not_century;
  logic        by_four;
  logic        leap;
  logic [8:0]  k_adj;
  logic [8:0]  doy;

  always_comb begin
    rdy[1] = !vld[1] || out_ready;
    rdy[0] = !vld[0] || rdy[1];
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld[1];
  assign out_data  = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= in_valid;
      if (rdy[1]) vld[1] <= vld[0];
    end
  end

  // Stage 9: range check, year / 100
  assign err_next = ($signed(in_data.year) < $signed(16'(dnc_pkg::YEAR_MIN))) ||
                    ($signed(in_data.year) > $signed(16'(dnc_pkg::YEAR_MAX)));
  assign y_prod   = 29'(in_data.year[13:0]) * 29'(dnc_pkg::Y100_MULT);

  // Stage 10: leap rule, day of year, blanking on range error
  assign hundreds    = 15'(q9) * 15'(dnc_pkg::Y100_DIV);
  assign not_century = hundreds != {1'b0, y9};
  assign by_four     = y9[1:0] == 2'b00;
  assign leap        = jul9 ? by_four : (by_four && (not_century || q9[1:0] == 2'b00));
  // Leap years lose one day after February, common years two
  assign k_adj       = (m9 >= 4'(dnc_pkg::MARCH)) ? (leap ? 9'd1 : 9'd2) : 9'd0;
  assign doy         = dnc_pkg::month_base(m9) - k_adj + 9'(d9);

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      y9   <= in_data.year[13:0];
      q9   <= y_prod[dnc_pkg::Y100_SHIFT +: 8];
      m9   <= in_data.month;
      d9   <= in_data.day;
      jul9 <= in_data.julian;
      err9 <= err_next;
    end
    if (rdy[1]) begin
      res.year        <= err9 ? '0 : y9;
      res.month       <= err9 ? '0 : m9;
      res.day         <= err9 ? '0 : d9;
      res.doy         <= err9 ? '0 : doy;
      res.leap        <= err9 ? 1'b0 : leap;
      res.range_error <= err9;
    end
  end

endmodule

// ===== design/day_number_to_calendar_date_unit.sv =====
// Converts a whole modified Julian day number into year, month, day of month,
// day of year and a leap-year flag, using the Julian calendar before
// 1582-10-15 and the Gregorian calendar from then on. The pipeline is ten
// register stages deep, and one item can be taken every cycle while the
// output side keeps up. Each stage holds its item until the next stage has
// room, so a stall on the output fills the pipeline from the back and input
// ready drops only once every stage is occupied. Dates outside years 1 to
// 9999 give tuser set and all data fields zero.
module day_number_to_calendar_date_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [22:0] day_number, [23] pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [13:0] year, [17:14] month,
                                      // [22:18] day_of_month, [31:23] day_of_year,
                                      // [32] leap_flag, [39:33] zero
  output logic        m_axis_tuser    // [0] range_error
);

  logic           mid_valid;
  logic           mid_ready;
  dnc_pkg::mid_t  mid_data;
  logic           date_valid;
  logic           date_ready;
  dnc_pkg::date_t date_data;
  dnc_pkg::res_t  res;

  // Stages 1-4: JD, Gregorian correction, B and C numerator
  dnc_gregory u_gregory (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .mjd       (s_axis_tdata[22:0]),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .out_data  (mid_data)
  );

  // Stages 5-8: C, D, E and the calendar date
  dnc_split u_split (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mid_valid),
    .in_ready  (mid_ready),
    .in_data   (mid_data),
    .out_valid (date_valid),
    .out_ready (date_ready),
    .out_data  (date_data)
  );

  // Stages 9-10: range check, leap rule, day of year
  dnc_finish u_finish (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (date_valid),
    .in_ready  (date_ready),
    .in_data   (date_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (res)
  );

  // Result packing
  assign m_axis_tdata = {7'd0, res.leap, res.doy, res.day, res.month, res.year};
  assign m_axis_tuser = res.range_error;

endmodule
